>>> hdl/string_escape_decoder_top_defines.svh
// assertion macros shared by the checker of the escape decoder
// depends on nothing; each macro expands to one labelled concurrent assertion
`ifndef STRING_ESCAPE_DECODER_TOP_DEFINES_SVH
`define STRING_ESCAPE_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SED_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, disabled while reset is low
`define SED_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> hdl/sed_pkg.sv
// shared types, constants and helper functions of the string escape decoder
// no dependencies; imported by the top level and its checker
package sed_pkg;

	localparam int MAX_RES = 5;
	localparam int ENC_MAX = 4;

	// decoder modes
	typedef enum logic [5:0] {
		MODE_PLAIN  = 6'b000001,
		MODE_BSLASH = 6'b000010,
		MODE_HEX2   = 6'b000100,
		MODE_HEX4   = 6'b001000,
		MODE_HEX8   = 6'b010000,
		MODE_OCT    = 6'b100000
	} mode_t;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BSLASH_END = 3'd1;
	localparam logic [2:0] ST_BAD_DIGIT  = 3'd2;
	localparam logic [2:0] ST_UNKNOWN    = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE  = 3'd4;

	// characters of the escape syntax
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_7   = 8'h37;
	localparam logic [7:0] CH_8   = 8'h38;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_V   = 8'h76;
	localparam logic [7:0] CH_F   = 8'h66;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_T   = 8'h74;
	localparam logic [7:0] CH_X   = 8'h78;
	localparam logic [7:0] CH_U   = 8'h75;
	localparam logic [7:0] CH_BIGU = 8'h55;

	// digit offsets: lower and upper case letters start at ten
	localparam logic [7:0] HEX_LOWER_BASE = 8'h57;
	localparam logic [7:0] HEX_UPPER_BASE = 8'h37;

	// decoded control bytes
	localparam logic [7:0] BYTE_VT  = 8'h0B;
	localparam logic [7:0] BYTE_FF  = 8'h0C;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_TAB = 8'h09;

	localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;
	localparam logic [31:0] OCT_LIMIT      = 32'd32;
	localparam logic [3:0]  OCT_DIGITS     = 4'd3;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic       empty;
		logic [2:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [2:0]              cnt;
		logic [ENC_MAX-1:0][7:0] bytes;
	} enc_t;

	// value of one hex digit, ok low when the byte is no digit
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c inside {[CH_0:CH_9]})
			h.val = 4'(c - CH_0);
		else if (c inside {[CH_LA:CH_LF]})
			h.val = 4'(c - HEX_LOWER_BASE);
		else if (c inside {[CH_UA:CH_UF]})
			h.val = 4'(c - HEX_UPPER_BASE);
		else
			h.ok = 1'b0;
		return h;
	endfunction

	// bytes of a completed escape: one raw byte, or utf-8 for a code point in range
	function automatic enc_t utf8_encode(input mode_t m, input logic [31:0] w);
		enc_t e;
		e.cnt   = 3'd1;
		e.bytes = '0;
		if (m == MODE_HEX2 || m == MODE_OCT) begin
			e.bytes[0] = w[7:0];
		end else if (w < 32'h0000_0080) begin
			e.bytes[0] = w[7:0];
		end else if (w < 32'h0000_0800) begin
			e.cnt      = 3'd2;
			e.bytes[0] = {3'b110, w[10:6]};
			e.bytes[1] = {2'b10, w[5:0]};
		end else if (w < 32'h0001_0000) begin
			e.cnt      = 3'd3;
			e.bytes[0] = {4'b1110, w[15:12]};
			e.bytes[1] = {2'b10, w[11:6]};
			e.bytes[2] = {2'b10, w[5:0]};
		end else begin
			e.cnt      = 3'd4;
			e.bytes[0] = {5'b11110, w[20:18]};
			e.bytes[1] = {2'b10, w[17:12]};
			e.bytes[2] = {2'b10, w[11:6]};
			e.bytes[3] = {2'b10, w[5:0]};
		end
		return e;
	endfunction

endpackage

>>> hdl/string_escape_decoder_top.sv
// string escape decoder: one string-body byte in per item, decoded bytes out
// uses sed_pkg for modes, status codes, digit decode and utf-8 encode
// an item waits in the input register until the result buffer can take its results, which then drive the output
// throughput: one item per cycle while each gives at most one result and the receiver
// takes it; an item with more results holds the input as the result buffer drains
// reset: arst_n low clears mode, escape value, digit count, discard flag, input valid and result count
module string_escape_decoder_top
	import sed_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       has_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_empty,
	output logic [2:0] status,
	output logic       out_last
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       hb_s1;
	logic       last_s1;

	// decoder state
	mode_t       mode_q;
	logic [31:0] val_q;
	logic [3:0]  cnt_q;
	logic        disc_q;

	// result buffer, head at entry 0
	res_t       buf_q [MAX_RES];
	logic [2:0] rem_q;

	// decode results
	mode_t       mode_d;
	logic [31:0] val_d;
	logic [3:0]  cnt_d;
	logic        disc_d;
	res_t        res_d [MAX_RES];
	logic [2:0]  n_d;

	logic s1_take;
	logic out_take;

	// handshake
	assign s1_take  = valid_s1 && (rem_q == 3'd0 || (rem_q == 3'd1 && out_ready));
	assign in_ready = !valid_s1 || s1_take;
	assign out_take = out_valid && out_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			hb_s1   <= has_byte;
			last_s1 <= in_last;
		end
	end

	// decode one item against the current state
	always_comb begin
		mode_t       m;
		logic [31:0] v;
		logic [3:0]  k;
		logic [2:0]  st;
		logic        cmp_go;
		mode_t       cmp_mode;
		logic [31:0] cmp_val;
		logic        take_plain;
		logic        plain_go;
		logic [7:0]  plain_byte;
		hex_t        hd;
		logic [31:0] nv_hex;
		logic [31:0] nv_oct;
		logic [3:0]  nk;
		logic [3:0]  lim;
		enc_t        enc;

		m          = mode_q;
		v          = val_q;
		k          = cnt_q;
		st         = ST_OK;
		cmp_go     = 1'b0;
		cmp_mode   = mode_q;
		cmp_val    = val_q;
		take_plain = 1'b0;
		plain_go   = 1'b0;
		plain_byte = byte_s1;
		hd         = hex_digit(byte_s1);
		nv_hex     = {val_q[27:0], hd.val};
		nv_oct     = {val_q[28:0], byte_s1[2:0]};
		nk         = cnt_q + 4'd1;
		lim        = (mode_q == MODE_HEX2) ? 4'd2 : ((mode_q == MODE_HEX4) ? 4'd4 : 4'd8);

		// the byte itself
		if (hb_s1) begin
			case (mode_q)
				MODE_HEX2, MODE_HEX4, MODE_HEX8: begin
					if (hd.ok) begin
						v = nv_hex;
						k = nk;
						if (nk >= lim) begin
							if (mode_q != MODE_HEX2 && nv_hex > MAX_CODE_POINT) begin
								st = ST_TOO_LARGE;
							end else begin
								cmp_go  = 1'b1;
								cmp_val = nv_hex;
							end
							m = MODE_PLAIN;
							v = '0;
							k = '0;
						end
					end else if (cnt_q == 4'd0) begin
						st = ST_BAD_DIGIT;
					end else if (mode_q != MODE_HEX2 && val_q > MAX_CODE_POINT) begin
						st = ST_TOO_LARGE;
					end else begin
						cmp_go     = 1'b1;
						m          = MODE_PLAIN;
						v          = '0;
						k          = '0;
						take_plain = 1'b1;
					end
				end
				MODE_OCT: begin
					if (byte_s1 inside {[CH_0:CH_7]} && cnt_q < OCT_DIGITS
							&& val_q < OCT_LIMIT) begin
						v = nv_oct;
						k = nk;
						if (nk >= OCT_DIGITS || nv_oct >= OCT_LIMIT) begin
							cmp_go  = 1'b1;
							cmp_val = nv_oct;
							m       = MODE_PLAIN;
							v       = '0;
							k       = '0;
						end
					end else begin
						cmp_go     = 1'b1;
						m          = MODE_PLAIN;
						v          = '0;
						k          = '0;
						take_plain = 1'b1;
					end
				end
				MODE_BSLASH: begin
					m = MODE_PLAIN;
					case (byte_s1)
						CH_V: begin
							plain_go   = 1'b1;
							plain_byte = BYTE_VT;
						end
						CH_F: begin
							plain_go   = 1'b1;
							plain_byte = BYTE_FF;
						end
						CH_R: begin
							plain_go   = 1'b1;
							plain_byte = BYTE_CR;
						end
						CH_N: begin
							plain_go   = 1'b1;
							plain_byte = BYTE_LF;
						end
						CH_T: begin
							plain_go   = 1'b1;
							plain_byte = BYTE_TAB;
						end
						CH_DQ, CH_BSL: begin
							plain_go = 1'b1;
						end
						CH_X:    m = MODE_HEX2;
						CH_U:    m = MODE_HEX4;
						CH_BIGU: m = MODE_HEX8;
						default: begin
							if (byte_s1 inside {[CH_0:CH_7]}) begin
								m = MODE_OCT;
								v = {29'd0, byte_s1[2:0]};
								k = 4'd1;
							end else if (byte_s1 == CH_8 || byte_s1 == CH_9) begin
								st = ST_BAD_DIGIT;
							end else begin
								st = ST_UNKNOWN;
							end
						end
					endcase
				end
				default: take_plain = 1'b1;
			endcase

			// byte that ended a short escape, or a plain byte
			if (take_plain) begin
				if (byte_s1 == CH_BSL)
					m = MODE_BSLASH;
				else
					plain_go = 1'b1;
			end
		end

		// end of string closes any pending escape
		if (st == ST_OK && last_s1) begin
			case (m)
				MODE_BSLASH: st = ST_BSLASH_END;
				MODE_HEX2, MODE_HEX4, MODE_HEX8: begin
					if (k == 4'd0) begin
						st = ST_BAD_DIGIT;
					end else if (m != MODE_HEX2 && v > MAX_CODE_POINT) begin
						st = ST_TOO_LARGE;
					end else begin
						cmp_go   = 1'b1;
						cmp_mode = m;
						cmp_val  = v;
					end
				end
				MODE_OCT: begin
					cmp_go   = 1'b1;
					cmp_mode = m;
					cmp_val  = v;
				end
				default: ;
			endcase
		end

		enc = utf8_encode(cmp_mode, cmp_val);

		// assemble result items: escape bytes, plain byte, then end or error
		for (int i = 0; i < MAX_RES; i++)
			res_d[i] = '0;
		n_d = 3'd0;
		if (cmp_go) begin
			for (int i = 0; i < ENC_MAX; i++) begin
				if (3'(i) < enc.cnt)
					res_d[i].data = enc.bytes[i];
			end
			n_d = enc.cnt;
		end
		if (plain_go) begin
			res_d[n_d].data = plain_byte;
			n_d = n_d + 3'd1;
		end
		if (st != ST_OK) begin
			res_d[n_d].empty  = 1'b1;
			res_d[n_d].status = st;
			res_d[n_d].last   = 1'b1;
			n_d = n_d + 3'd1;
		end else if (last_s1) begin
			if (n_d != 3'd0) begin
				res_d[n_d - 3'd1].last = 1'b1;
			end else begin
				res_d[0].empty = 1'b1;
				res_d[0].last  = 1'b1;
				n_d = 3'd1;
			end
		end

		// next state
		mode_d = m;
		val_d  = v;
		cnt_d  = k;
		disc_d = 1'b0;
		if (st != ST_OK || last_s1) begin
			mode_d = MODE_PLAIN;
			val_d  = '0;
			cnt_d  = '0;
			disc_d = (st != ST_OK) && !last_s1;
		end

		// rest of an aborted string is dropped
		if (disc_q) begin
			for (int i = 0; i < MAX_RES; i++)
				res_d[i] = '0;
			n_d    = 3'd0;
			mode_d = mode_q;
			val_d  = val_q;
			cnt_d  = cnt_q;
			disc_d = !last_s1;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			val_q  <= '0;
			cnt_q  <= '0;
			disc_q <= 1'b0;
		end else if (s1_take) begin
			mode_q <= mode_d;
			val_q  <= val_d;
			cnt_q  <= cnt_d;
			disc_q <= disc_d;
		end
	end

	// result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (s1_take) begin
			rem_q <= n_d;
		end else if (out_take) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// result buffer payload, shifts towards the head as items leave
	always_ff @(posedge clk) begin
		if (s1_take) begin
			buf_q <= res_d;
		end else if (out_take) begin
			for (int i = 0; i < MAX_RES - 1; i++)
				buf_q[i] <= buf_q[i + 1];
		end
	end

	// output item
	assign out_valid = (rem_q != 3'd0);
	assign out_byte  = buf_q[0].data;
	assign out_empty = buf_q[0].empty;
	assign status    = buf_q[0].status;
	assign out_last  = buf_q[0].last;

endmodule

>>> hdl/sed_checker.sv
// port-level checks on the escape decoder's result channel
// depends on sed_pkg and string_escape_decoder_top_defines.svh; bound to the top level
`include "string_escape_decoder_top_defines.svh"

module sed_checker
	import sed_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_empty,
	input logic [2:0] status,
	input logic       out_last
);

	// an error item closes the string and carries no byte
	`SED_ASSERT_NOW(a_err_closes, clk, arst_n, out_valid && status != ST_OK, out_empty && out_last, "error item not empty and last")

	// an empty item only ever marks the end of a string
	`SED_ASSERT_NOW(a_empty_is_end, clk, arst_n, out_valid && out_empty, out_last && out_byte == 8'h00, "empty item not a clean end marker")

	// only defined status codes leave the block
	`SED_ASSERT_NOW(a_status_range, clk, arst_n, out_valid, status <= ST_TOO_LARGE, "undefined status code")

	// a stalled result item holds
	`SED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(status) && $stable(out_last) && $stable(out_empty), "stalled item changed")

	// with nothing pending the input is always open
	`SED_ASSERT_NOW(a_idle_ready, clk, arst_n, !out_valid, in_ready, "input closed with no result pending")

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (.*);

>>> tb/sv/escape_check_pkg.sv
// string escape decoder checking: item type and scoreboard with its own decoder model
// depends on sed_pkg for mode names, status codes, character codes and the result type
package escape_check_pkg;
	import sed_pkg::*;

	// one item of the string body as driven into the block
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} str_item_t;

	class escape_scoreboard;
		mode_t       mode;
		logic [31:0] acc;
		logic [3:0]  ndig;
		logic        dropping;
		res_t        batch[$];
		res_t        awaited_bytes[$];
		int          items_taken;
		int          results_seen;
		int          strings_done;
		int          mismatches;

		function new();
			restart();
			items_taken  = 0;
			results_seen = 0;
			strings_done = 0;
			mismatches   = 0;
		endfunction

		function void restart();
			mode     = MODE_PLAIN;
			acc      = '0;
			ndig     = '0;
			dropping = 1'b0;
		endfunction

		// queue one result of the current item, at most five per item
		function void emit(logic [7:0] b, logic e, logic [2:0] st, logic l);
			res_t r;
			if (batch.size() >= MAX_RES)
				return;
			r.data   = b;
			r.empty  = e;
			r.status = st;
			r.last   = l;
			batch.insert(batch.size(), r);
		endfunction

		function int digit_of(logic [7:0] c);
			if (c >= CH_0 && c <= CH_9)
				return int'(c - CH_0);
			if (c >= CH_LA && c <= CH_LF)
				return int'(c - HEX_LOWER_BASE);
			if (c >= CH_UA && c <= CH_UF)
				return int'(c - HEX_UPPER_BASE);
			return -1;
		endfunction

		// finish the pending escape: raw byte, utf-8 of the code point, or too large status
		function logic [2:0] close_escape();
			logic [31:0] v;
			mode_t       m;
			v    = acc;
			m    = mode;
			mode = MODE_PLAIN;
			acc  = '0;
			ndig = '0;
			if (m == MODE_HEX2 || m == MODE_OCT) begin
				emit(v[7:0], 1'b0, ST_OK, 1'b0);
				return ST_OK;
			end
			if (v > MAX_CODE_POINT)
				return ST_TOO_LARGE;
			if (v < 32'h80) begin
				emit(v[7:0], 1'b0, ST_OK, 1'b0);
			end else if (v < 32'h800) begin
				emit(8'hC0 | 8'(v >> 6), 1'b0, ST_OK, 1'b0);
				emit(8'h80 | 8'(v & 32'h3F), 1'b0, ST_OK, 1'b0);
			end else if (v < 32'h10000) begin
				emit(8'hE0 | 8'(v >> 12), 1'b0, ST_OK, 1'b0);
				emit(8'h80 | 8'((v >> 6) & 32'h3F), 1'b0, ST_OK, 1'b0);
				emit(8'h80 | 8'(v & 32'h3F), 1'b0, ST_OK, 1'b0);
			end else begin
				emit(8'hF0 | 8'(v >> 18), 1'b0, ST_OK, 1'b0);
				emit(8'h80 | 8'((v >> 12) & 32'h3F), 1'b0, ST_OK, 1'b0);
				emit(8'h80 | 8'((v >> 6) & 32'h3F), 1'b0, ST_OK, 1'b0);
				emit(8'h80 | 8'(v & 32'h3F), 1'b0, ST_OK, 1'b0);
			end
			return ST_OK;
		endfunction

		// decode one byte of the body in the current mode
		function logic [2:0] take_char(logic [7:0] c);
			int         d;
			int         lim;
			logic [2:0] st;
			if (mode == MODE_HEX2 || mode == MODE_HEX4 || mode == MODE_HEX8) begin
				lim = (mode == MODE_HEX2) ? 2 : ((mode == MODE_HEX4) ? 4 : 8);
				d   = digit_of(c);
				if (d >= 0) begin
					acc = {acc[27:0], 4'(d)};
					ndig++;
					if (ndig >= lim)
						return close_escape();
					return ST_OK;
				end
				if (ndig == 0)
					return ST_BAD_DIGIT;
				st = close_escape();
				if (st != ST_OK)
					return st;
			end else if (mode == MODE_OCT) begin
				if (c >= CH_0 && c <= CH_7 && ndig < OCT_DIGITS && acc < OCT_LIMIT) begin
					acc = {acc[28:0], 3'(c - CH_0)};
					ndig++;
					if (ndig >= OCT_DIGITS || acc >= OCT_LIMIT)
						return close_escape();
					return ST_OK;
				end
				st = close_escape();
				if (st != ST_OK)
					return st;
			end else if (mode == MODE_BSLASH) begin
				mode = MODE_PLAIN;
				case (c)
					CH_V: begin
						emit(BYTE_VT, 1'b0, ST_OK, 1'b0);
						return ST_OK;
					end
					CH_F: begin
						emit(BYTE_FF, 1'b0, ST_OK, 1'b0);
						return ST_OK;
					end
					CH_R: begin
						emit(BYTE_CR, 1'b0, ST_OK, 1'b0);
						return ST_OK;
					end
					CH_N: begin
						emit(BYTE_LF, 1'b0, ST_OK, 1'b0);
						return ST_OK;
					end
					CH_T: begin
						emit(BYTE_TAB, 1'b0, ST_OK, 1'b0);
						return ST_OK;
					end
					CH_DQ: begin
						emit(CH_DQ, 1'b0, ST_OK, 1'b0);
						return ST_OK;
					end
					CH_BSL: begin
						emit(CH_BSL, 1'b0, ST_OK, 1'b0);
						return ST_OK;
					end
					CH_X: begin
						mode = MODE_HEX2;
						return ST_OK;
					end
					CH_U: begin
						mode = MODE_HEX4;
						return ST_OK;
					end
					CH_BIGU: begin
						mode = MODE_HEX8;
						return ST_OK;
					end
					default: ;
				endcase
				if (c >= CH_0 && c <= CH_7) begin
					mode = MODE_OCT;
					acc  = 32'(c - CH_0);
					ndig = 4'd1;
					return ST_OK;
				end
				if (c == CH_8 || c == CH_9)
					return ST_BAD_DIGIT;
				return ST_UNKNOWN;
			end
			// plain text, also the byte that ended a short escape
			mode = MODE_PLAIN;
			if (c == CH_BSL)
				mode = MODE_BSLASH;
			else
				emit(c, 1'b0, ST_OK, 1'b0);
			return ST_OK;
		endfunction

		// end of string: complete or reject whatever escape is open
		function logic [2:0] end_string();
			if (mode == MODE_BSLASH)
				return ST_BSLASH_END;
			if (mode == MODE_HEX2 || mode == MODE_HEX4 || mode == MODE_HEX8) begin
				if (ndig == 0)
					return ST_BAD_DIGIT;
				return close_escape();
			end
			if (mode == MODE_OCT)
				return close_escape();
			return ST_OK;
		endfunction

		// an accepted input item: work out and queue the results it causes
		function void note_item(str_item_t it);
			logic [2:0] st;
			res_t       tail;
			items_taken++;
			if (dropping) begin
				if (it.last)
					restart();
				return;
			end
			if (!it.has && !it.last)
				return;
			batch.delete();
			st = ST_OK;
			if (it.has)
				st = take_char(it.data);
			if (st == ST_OK && it.last)
				st = end_string();
			if (st != ST_OK) begin
				emit(8'h00, 1'b1, st, 1'b1);
				restart();
				if (!it.last)
					dropping = 1'b1;
				strings_done++;
			end else if (it.last) begin
				if (batch.size() > 0) begin
					tail      = batch[batch.size() - 1];
					tail.last = 1'b1;
					batch[batch.size() - 1] = tail;
				end else begin
					emit(8'h00, 1'b1, ST_OK, 1'b1);
				end
				restart();
				strings_done++;
			end
			foreach (batch[i])
				awaited_bytes.insert(awaited_bytes.size(), batch[i]);
		endfunction

		// an accepted result: compare with the oldest one awaited
		function void check_result(res_t got, longint unsigned stamp);
			res_t want;
			results_seen++;
			if (awaited_bytes.size() == 0) begin
				$display("%0d ns: result with none awaited: byte %h empty %b status %0d last %b",
					stamp, got.data, got.empty, got.status, got.last);
				mismatches++;
				return;
			end
			want = awaited_bytes.pop_front();
			if (got.data !== want.data) begin
				$display("%0d ns: out_byte expected %h actual %h", stamp, want.data, got.data);
				mismatches++;
			end
			if (got.empty !== want.empty) begin
				$display("%0d ns: out_empty expected %b actual %b", stamp, want.empty, got.empty);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0d ns: status expected %0d actual %0d", stamp, want.status, got.status);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0d ns: out_last expected %b actual %b", stamp, want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

endpackage

>>> tb/sv/string_escape_decoder_top_test.sv
// top of the string escape decoder testbench: clock, reset, stimulus and result monitor
// depends on sed_pkg, escape_check_pkg and the string_escape_decoder_top rtl
module string_escape_decoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sed_pkg::*;
	import escape_check_pkg::*;

	localparam int RANDOM_ITEMS = 380;
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 16;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       has_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       out_empty;
	logic [2:0] status;
	logic       out_last;

	escape_scoreboard board = new();
	str_item_t        string_items[$];
	str_item_t        seen_in;
	res_t             seen_out;
	int               burst_left;
	int               idle_cycles = 0;
	int               rx_cycle = 0;
	int               rx_mode = 0;
	int               target;

	logic [7:0] simple_esc [7] = '{CH_V, CH_F, CH_R, CH_N, CH_T, CH_DQ, CH_BSL};
	logic [7:0] wide_esc [3]   = '{CH_X, CH_U, CH_BIGU};

	string_escape_decoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.has_byte  (has_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_empty (out_empty),
		.status    (status),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: out_ready follows a stall pattern drawn anew at random from four
	always @(negedge clk) begin
		if (rx_cycle % 48 == 0)
			rx_mode = $urandom_range(0, 3);
		rx_cycle++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 9) < 4);
			default: out_ready <= (rx_cycle % 4 != 3);
		endcase
	end

	// handshake monitor and watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_in = {in_byte, has_byte, in_last};
				board.note_item(seen_in);
			end
			if (out_valid && out_ready) begin
				seen_out = {out_byte, out_empty, status, out_last};
				board.check_result(seen_out, $time);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results still awaited",
					$time, STALL_LIMIT, board.awaited_bytes.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function void add_item(logic [7:0] b, logic hb, logic l);
		str_item_t it;
		it.data = b;
		it.has  = hb;
		it.last = l;
		string_items.insert(string_items.size(), it);
	endfunction

	function void mark_last();
		str_item_t tail;
		tail      = string_items[string_items.size() - 1];
		tail.last = 1'b1;
		string_items[string_items.size() - 1] = tail;
	endfunction

	function int hex_len(logic [31:0] v);
		int n;
		n = 1;
		while (n < 8 && (v >> (4 * n)) != 0)
			n++;
		return n;
	endfunction

	// k hex digits of v, letters in either case
	function void add_hex(logic [31:0] v, int k);
		logic [3:0] d;
		logic [7:0] ch;
		for (int i = k - 1; i >= 0; i--) begin
			d = 4'(v >> (4 * i));
			if (d < 10)
				ch = CH_0 + 8'(d);
			else
				ch = ($urandom_range(0, 1) ? HEX_LOWER_BASE : HEX_UPPER_BASE) + 8'(d);
			add_item(ch, 1'b1, 1'b0);
		end
	endfunction

	// code point spread over the utf-8 length classes, with surrogates and values beyond range when wide
	function logic [31:0] tiered_value(bit wide);
		logic [31:0] v;
		case ($urandom_range(0, wide ? 7 : 2))
			0: v = $urandom_range(0, 32'h7F);
			1: v = $urandom_range(32'h80, 32'h7FF);
			2: v = $urandom_range(wide ? 32'h800 : 32'h0, 32'hFFFF);
			6: v = $urandom_range(32'hD800, 32'hDFFF);
			7: v = $urandom_range(32'h110000, 32'hFFFFFFFF);
			default: v = $urandom_range(32'h10000, 32'h10FFFF);
		endcase
		return v;
	endfunction

	// one random string: mostly well-formed escapes, some noise and errors
	function void compose_string();
		int          elems;
		int          pick;
		logic [31:0] v;
		bit          closed;
		elems  = $urandom_range(0, 7);
		closed = 1'b0;
		for (int e = 0; e < elems && !closed; e++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				v = $urandom_range(0, 255);
				if (v[7:0] == CH_BSL)
					add_item(CH_BSL, 1'b1, 1'b0);
				add_item(v[7:0], 1'b1, 1'b0);
			end else if (pick < 45) begin
				add_item(CH_BSL, 1'b1, 1'b0);
				add_item(simple_esc[$urandom_range(0, 6)], 1'b1, 1'b0);
			end else if (pick < 55) begin
				v = $urandom_range(0, 255);
				add_item(CH_BSL, 1'b1, 1'b0);
				add_item(CH_X, 1'b1, 1'b0);
				add_hex(v, $urandom_range(hex_len(v), 2));
			end else if (pick < 65) begin
				v = tiered_value(1'b0);
				add_item(CH_BSL, 1'b1, 1'b0);
				add_item(CH_U, 1'b1, 1'b0);
				add_hex(v, $urandom_range(hex_len(v), 4));
			end else if (pick < 78) begin
				v = tiered_value(1'b1);
				add_item(CH_BSL, 1'b1, 1'b0);
				add_item(CH_BIGU, 1'b1, 1'b0);
				add_hex(v, $urandom_range(hex_len(v), 8));
			end else if (pick < 88) begin
				add_item(CH_BSL, 1'b1, 1'b0);
				repeat ($urandom_range(1, 3))
					add_item(CH_0 + 8'($urandom_range(0, 7)), 1'b1, 1'b0);
			end else if (pick < 92) begin
				add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end else begin
				// broken escapes
				add_item(CH_BSL, 1'b1, 1'b0);
				case ($urandom_range(0, 4))
					0: add_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
					1: add_item($urandom_range(0, 1) ? CH_8 : CH_9, 1'b1, 1'b0);
					2: begin
						add_item(wide_esc[$urandom_range(0, 2)], 1'b1, 1'b0);
						add_item(8'($urandom_range(8'h67, 8'h7A)), 1'b1, 1'b0);
					end
					3: closed = 1'b1;
					default: begin
						add_item(wide_esc[$urandom_range(0, 2)], 1'b1, 1'b0);
						closed = 1'b1;
					end
				endcase
			end
		end
		// close on the last byte or with a separate end marker
		if (!closed && (string_items.size() == 0 || $urandom_range(0, 3) == 0))
			add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		else
			mark_last();
	endfunction

	task automatic send_item(str_item_t it);
		@(negedge clk);
		in_valid = 1'b1;
		in_byte  = it.data;
		has_byte = it.has;
		in_last  = it.last;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic hold_off(int n);
		if (n == 0)
			return;
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.awaited_bytes.size() != 0)
			@(posedge clk);
	endtask

	// send the composed string, in bursts when asked
	task automatic send_string(bit bursty);
		foreach (string_items[i]) begin
			if (bursty) begin
				if (burst_left == 0) begin
					hold_off($urandom_range(1, 6));
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
						$urandom_range(1, 12);
				end
				burst_left--;
			end
			send_item(string_items[i]);
		end
		string_items.delete();
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_byte    = 8'h00;
		has_byte   = 1'b0;
		in_last    = 1'b0;
		burst_left = 0;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// byte extremes, an ignored empty item and an end marker
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'hFF, 1'b1, 1'b0);
		add_item(8'hA5, 1'b0, 1'b0);
		add_item(8'h5A, 1'b0, 1'b1);
		// code point beyond the unicode range, completed by the end of the string
		add_item(CH_BSL, 1'b1, 1'b0);
		add_item(CH_BIGU, 1'b1, 1'b0);
		add_hex(32'h110000, 6);
		mark_last();
		// lone backslash closing the string
		add_item(CH_BSL, 1'b1, 1'b1);
		// hex escape without a digit, the rest is dropped
		add_item(CH_BSL, 1'b1, 1'b0);
		add_item(CH_X, 1'b1, 1'b0);
		add_item(8'h67, 1'b1, 1'b0);
		add_item(8'h7A, 1'b1, 1'b1);
		// unknown escape letter
		add_item(CH_BSL, 1'b1, 1'b0);
		add_item(8'h71, 1'b1, 1'b1);
		// octal of three digits, then a plain digit
		add_item(CH_BSL, 1'b1, 1'b0);
		add_item(CH_0 + 8'd1, 1'b1, 1'b0);
		add_item(CH_0 + 8'd2, 1'b1, 1'b0);
		add_item(CH_0 + 8'd3, 1'b1, 1'b0);
		add_item(CH_0 + 8'd4, 1'b1, 1'b1);
		// short U escape giving four utf-8 bytes, then a backslash at the end
		add_item(CH_BSL, 1'b1, 1'b0);
		add_item(CH_BIGU, 1'b1, 1'b0);
		add_hex(32'h1F600, 5);
		add_item(CH_BSL, 1'b1, 1'b1);
		send_string(1'b0);
		wait_drained();

		// random strings, now and then letting the output run dry
		target = board.items_taken + RANDOM_ITEMS;
		while (board.items_taken < target) begin
			compose_string();
			send_string(1'b1);
			if ($urandom_range(0, 29) == 0)
				wait_drained();
		end
		wait_drained();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("decoded %0d strings from %0d items, %0d results checked, %0d mismatches",
			board.strings_done, board.items_taken, board.results_seen, board.mismatches);
		$display("plain bytes, simple, hex, u, U and octal escapes, utf-8 lengths and all errors");
		if (board.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/sed_pkg.sv
hdl/string_escape_decoder_top.sv
hdl/sed_checker.sv
tb/sv/escape_check_pkg.sv
tb/sv/string_escape_decoder_top_test.sv
